/* src/dq_pkg.sv */
// Shared types and codes for the double-ended queue.
// Used by dq_ring, dq_ctrl, the top level double_ended_queue and the checker dq_checker.
package dq_pkg;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_REAR   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int          WORD_W      = 32;
  localparam int          CFG_W       = 5;
  localparam int          CAP_DEFAULT = 16;
  localparam logic [31:0] WORD_ALL_ONES = 32'hFFFF_FFFF;

  // Memory access request from the index controller to the ring.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

  // Per-transaction result information that does not come from the ring.
  typedef struct packed {
    logic       is_pop;
    logic [1:0] status;
  } res_info_t;

endpackage

/* src/dq_ring.sv */
// Ring storage of the double-ended queue: one synchronous memory with a
// registered read port. Depends on nothing but its parameters and dq_pkg.
module dq_ring #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  dq_pkg::mem_cmd_t                  cmd,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [dq_pkg::WORD_W-1:0]         wdata,
  output logic [dq_pkg::WORD_W-1:0]         rdata
);

  logic [dq_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* src/dq_ctrl.sv */
// Index controller of the double-ended queue: front and rear indices, empty
// flag and capacity register. Issues at most one ring access per transaction.
// Depends on dq_pkg.
module dq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [dq_pkg::CFG_W-1:0]      cfg_data,
  input  logic                          go,
  input  logic [1:0]                    op,
  output dq_pkg::mem_cmd_t              cmd,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  output dq_pkg::res_info_t             res
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W = ($clog2(DEPTH + 1) > dq_pkg::CFG_W) ? $clog2(DEPTH + 1)
                                                             : dq_pkg::CFG_W;
  localparam int CAP_RST = (dq_pkg::CAP_DEFAULT > DEPTH) ? DEPTH : dq_pkg::CAP_DEFAULT;

  logic [IDX_W-1:0] front, front_next;
  logic [IDX_W-1:0] rear, rear_next;
  logic             empty, empty_next;
  logic [CAP_W-1:0] cap;

  logic [CAP_W-1:0] cfg_ext, cfg_clamped, cap_m1_w;
  logic [CAP_W-1:0] front_inc, rear_inc;
  logic [IDX_W-1:0] cap_m1, front_up, front_dn, rear_up, rear_dn;
  logic             full, is_pop;

  // Zero is taken as one slot, anything beyond the ring as the whole ring.
  always_comb begin
    cfg_ext = CAP_W'(cfg_data);
    if (cfg_ext == '0) begin
      cfg_clamped = CAP_W'(1);
    end else if (cfg_ext > CAP_W'(DEPTH)) begin
      cfg_clamped = CAP_W'(DEPTH);
    end else begin
      cfg_clamped = cfg_ext;
    end
  end

  assign cap_m1_w  = cap - CAP_W'(1);
  assign cap_m1    = cap_m1_w[IDX_W-1:0];
  assign front_inc = CAP_W'(front) + CAP_W'(1);
  assign rear_inc  = CAP_W'(rear) + CAP_W'(1);
  assign front_up  = (front_inc >= cap) ? '0 : front_inc[IDX_W-1:0];
  assign rear_up   = (rear_inc >= cap) ? '0 : rear_inc[IDX_W-1:0];
  assign front_dn  = (front == '0) ? cap_m1 : front - IDX_W'(1);
  assign rear_dn   = (rear == '0) ? cap_m1 : rear - IDX_W'(1);
  assign full      = !empty && (rear_up == front);
  assign is_pop    = (op == dq_pkg::OP_POP_FRONT) || (op == dq_pkg::OP_POP_REAR);

  always_comb begin
    front_next = front;
    rear_next  = rear;
    empty_next = empty;
    cmd        = '0;
    addr       = '0;
    res.is_pop = is_pop;
    res.status = dq_pkg::ST_DONE;
    case (op)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          res.status = dq_pkg::ST_FULL;
        end else if (empty) begin
          front_next = '0;
          rear_next  = '0;
          empty_next = 1'b0;
          cmd.wr_en  = go;
          addr       = '0;
        end else if (op == dq_pkg::OP_PUSH_FRONT) begin
          front_next = front_dn;
          cmd.wr_en  = go;
          addr       = front_dn;
        end else begin
          rear_next = rear_up;
          cmd.wr_en = go;
          addr      = rear_up;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
        if (empty) begin
          res.status = dq_pkg::ST_EMPTY;
        end else begin
          cmd.rd_en = go;
          addr      = (op == dq_pkg::OP_POP_FRONT) ? front : rear;
          if (front == rear) begin
            // Removing the last word empties the queue.
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b1;
          end else if (op == dq_pkg::OP_POP_FRONT) begin
            front_next = front_up;
          end else begin
            rear_next = rear_dn;
          end
        end
      end
      default: begin
        res.status = dq_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
      cap   <= CAP_W'(CAP_RST);
    end else if (cfg_valid) begin
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
      cap   <= cfg_clamped;
    end else if (go) begin
      front <= front_next;
      rear  <= rear_next;
      empty <= empty_next;
    end
  end

endmodule

/* src/double_ended_queue.sv */
// Top level of the double-ended queue: stream ports, result stage and output
// register. Depends on dq_pkg, dq_ctrl and dq_ring.
//
// Usage:
//   Each input transaction on s_* carries one operation in s_tuser (push
//   front, push rear, pop front, pop rear) and, for pushes, the word in
//   s_tdata. Every input transaction gives exactly one output transaction on
//   m_*: the popped word (or -1 for a pop on an empty queue, 0 for pushes) in
//   m_tdata and the status in m_tuser (done, rejected full, rejected empty).
//   The cfg_* channel sets the number of ring slots used (1..DEPTH, zero is
//   taken as 1, larger values as DEPTH) and empties the queue; write it only
//   while no transaction is in flight. cfg_ready is always high.
// Timing:
//   One operation per cycle sustained while m_tready is high. A result
//   reaches m_* through the ring access with the result stage (the memory
//   read) and then the output register.
// Reset:
//   rst empties the queue, sets the capacity to 16 slots (or DEPTH if it is
//   smaller) and drops m_tvalid. Ring contents are not cleared.
// Backpressure:
//   With m_tready low, one result waits in the output register and one more
//   in the result stage; s_tready then falls until the output drains.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] push_value
  input  logic [1:0]  s_tuser,  // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] pop_value
  output logic [1:0]  m_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dq_pkg::mem_cmd_t          cmd;
  dq_pkg::res_info_t         res;
  logic [IDX_W-1:0]          addr;
  logic [dq_pkg::WORD_W-1:0] rdata;

  logic       go, advance;
  logic       p_valid;
  logic       p_is_pop;
  logic [1:0] p_status;

  assign cfg_ready = 1'b1;
  assign advance   = p_valid && (!m_tvalid || m_tready);
  assign s_tready  = !p_valid || advance;
  assign go        = s_tvalid && s_tready;

  dq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .go        (go),
    .op        (s_tuser),
    .cmd       (cmd),
    .addr      (addr),
    .res       (res)
  );

  dq_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk   (clk),
    .cmd   (cmd),
    .addr  (addr),
    .wdata (s_tdata),
    .rdata (rdata)
  );

  // The ring read data holds while the result stage stalls, because a new
  // read is only issued when the stage moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (go) begin
        p_valid <= 1'b1;
      end else if (advance) begin
        p_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (go) begin
      p_is_pop <= res.is_pop;
      p_status <= res.status;
    end
    if (advance) begin
      m_tuser <= p_status;
      if (!p_is_pop) begin
        m_tdata <= '0;
      end else if (p_status == dq_pkg::ST_EMPTY) begin
        m_tdata <= dq_pkg::WORD_ALL_ONES;
      end else begin
        m_tdata <= rdata;
      end
    end
  end

endmodule

/* src/dq_checker.sv */
// Port-level checks for the double-ended queue and the bind that attaches
// them to double_ended_queue. Depends on dq_pkg.
module dq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == dq_pkg::ST_DONE || m_tuser == dq_pkg::ST_FULL ||
                  m_tuser == dq_pkg::ST_EMPTY))
    else $error("undefined status code");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == dq_pkg::ST_EMPTY) |-> m_tdata == dq_pkg::WORD_ALL_ONES)
    else $error("rejected pop does not return -1");

  a_full_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == dq_pkg::ST_FULL) |-> m_tdata == '0)
    else $error("rejected push does not return zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output transaction changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* tb/tb_double_ended_queue.sv */
// Self-checking testbench for double_ended_queue: directed and random deque
// operations, predicted by a behavioral copy of the ring and compared on m_*.
// Depends on dq_pkg and the RTL top level double_ended_queue.
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH_SLOTS  = 16;
  localparam int MAX_CYCLES   = 200000;
  localparam int SHOWN_ERRORS = 10;
  localparam int OPS_PER_RUN  = 120;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] word;
  } deque_op_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } deque_res_t;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = dq_pkg::OP_PUSH_FRONT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  // Behavioral copy of the deque.
  logic [31:0] ring_copy [DEPTH_SLOTS];
  int          front_at;
  int          rear_at;
  bit          queue_empty;
  logic [4:0]  capacity_reg;

  deque_op_t   pending_ops[$];
  deque_res_t  expected_results[$];
  int          mismatches   = 0;
  int          accepted_ops = 0;
  int          cycles       = 0;
  bit          took_op      = 1'b0;

  int          burst_left   = 0;
  int          gap_left     = 0;
  int          hold_left    = 0;
  int          next_hold_at = 250;
  int          mode_left    = 0;
  rx_mode_t    rx_mode      = RX_ALWAYS;

  logic [31:0] corner_words [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};

  double_ended_queue #(.DEPTH(DEPTH_SLOTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] push_value
    .s_tuser  (s_tuser),   // [1:0] op
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [31:0] pop_value
    .m_tuser  (m_tuser),   // [1:0] status
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int wrap_up(int idx, int cap);
    return (idx + 1 >= cap) ? 0 : idx + 1;
  endfunction

  // Applies one operation to the copy of the deque and returns its result.
  function automatic deque_res_t apply_deque_op(deque_op_t item);
    int         cap;
    bit         full;
    deque_res_t res;
    cap = (capacity_reg == 0) ? 1 :
          (capacity_reg > DEPTH_SLOTS) ? DEPTH_SLOTS : int'(capacity_reg);
    res.value  = '0;
    res.status = dq_pkg::ST_DONE;
    if (front_at >= cap) front_at = 0;
    if (rear_at >= cap) rear_at = 0;
    full = !queue_empty && (wrap_up(rear_at, cap) == front_at);
    if (item.op == dq_pkg::OP_PUSH_FRONT || item.op == dq_pkg::OP_PUSH_REAR) begin
      if (full) begin
        res.status = dq_pkg::ST_FULL;
      end else if (queue_empty) begin
        // The first word always lands in slot zero.
        front_at     = 0;
        rear_at      = 0;
        queue_empty  = 1'b0;
        ring_copy[0] = item.word;
      end else if (item.op == dq_pkg::OP_PUSH_FRONT) begin
        front_at            = (front_at == 0) ? cap - 1 : front_at - 1;
        ring_copy[front_at] = item.word;
      end else begin
        rear_at            = wrap_up(rear_at, cap);
        ring_copy[rear_at] = item.word;
      end
    end else if (queue_empty) begin
      res.status = dq_pkg::ST_EMPTY;
      res.value  = dq_pkg::WORD_ALL_ONES;
    end else begin
      res.value = (item.op == dq_pkg::OP_POP_FRONT) ? ring_copy[front_at]
                                                    : ring_copy[rear_at];
      if (front_at == rear_at) begin
        front_at    = 0;
        rear_at     = 0;
        queue_empty = 1'b1;
      end else if (item.op == dq_pkg::OP_POP_FRONT) begin
        front_at = wrap_up(front_at, cap);
      end else begin
        rear_at = (rear_at == 0) ? cap - 1 : rear_at - 1;
      end
    end
    return res;
  endfunction

  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Prediction on accepted inputs and checking of accepted results.
  always @(posedge clk) begin
    deque_op_t  item;
    deque_res_t want;
    if (rst) begin
      front_at     = 0;
      rear_at      = 0;
      queue_empty  = 1'b1;
      capacity_reg = 5'(dq_pkg::CAP_DEFAULT);
    end else begin
      if (cfg_valid && cfg_ready) begin
        // A capacity write empties the queue but keeps the ring words.
        capacity_reg = cfg_data;
        front_at     = 0;
        rear_at      = 0;
        queue_empty  = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        item.op   = s_tuser;
        item.word = s_tdata;
        expected_results.push_back(apply_deque_op(item));
        accepted_ops++;
        took_op = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.value)
            report_mismatch("pop_value", want.value, m_tdata);
          if (m_tuser !== want.status)
            report_mismatch("status", {30'd0, want.status}, {30'd0, m_tuser});
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    deque_op_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      took_op  = 1'b0;
    end else if (!s_tvalid || took_op) begin
      took_op = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        item = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= item.word;
        s_tuser  <= item.op;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: changing stall patterns, plus a long hold-off now and then
  // while the sender still has plenty queued, so the block backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (accepted_ops >= next_hold_at && pending_ops.size() > 20) begin
      hold_left    = 200;
      next_hold_at = next_hold_at + 700;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS:   m_tready <= 1'b1;
        RX_MOSTLY:   m_tready <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: m_tready <= ((mode_left % 4) != 0);
        default:     m_tready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_op(logic [1:0] op, logic [31:0] word);
    deque_op_t item;
    item.op   = op;
    item.word = word;
    pending_ops.push_back(item);
  endtask

  function automatic deque_op_t random_op(int push_pct);
    deque_op_t item;
    bit        is_push;
    bit        at_front;
    is_push  = ($urandom_range(0, 99) < push_pct);
    at_front = 1'($urandom_range(0, 1));
    if (is_push)
      item.op = at_front ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_REAR;
    else
      item.op = at_front ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_REAR;
    item.word = ($urandom_range(0, 7) == 0) ? corner_words[$urandom_range(0, 3)] : $urandom;
    return item;
  endfunction

  // Waits until every transaction has been sent and answered, then lets the
  // pipeline settle before any capacity write.
  task automatic wait_until_idle();
    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do
      @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    logic [4:0] caps[$];
    int         push_pct;
    int         bias_left;
    caps = '{5'd31, 5'd1, 5'd2, 5'd3, 5'd4, 5'd7, 5'd16, 5'd17, 5'd5, 5'd9, 5'd12};
    push_pct  = 50;
    bias_left = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset capacity: pops on an empty queue, extreme words from both ends,
    // a push at the front that wraps the index, and draining past empty.
    add_op(dq_pkg::OP_POP_FRONT, 32'h0);
    add_op(dq_pkg::OP_POP_REAR, 32'h1234_5678);
    add_op(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    add_op(dq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    add_op(dq_pkg::OP_PUSH_REAR, 32'hFFFF_FFFF);
    add_op(dq_pkg::OP_PUSH_REAR, 32'h0000_0000);
    add_op(dq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
    add_op(dq_pkg::OP_PUSH_REAR, 32'h5555_5555);
    add_op(dq_pkg::OP_POP_REAR, 32'h0);
    add_op(dq_pkg::OP_POP_FRONT, 32'h0);
    add_op(dq_pkg::OP_POP_FRONT, 32'h0);
    add_op(dq_pkg::OP_POP_REAR, 32'h0);
    add_op(dq_pkg::OP_POP_FRONT, 32'h0);
    add_op(dq_pkg::OP_POP_REAR, 32'h0);
    add_op(dq_pkg::OP_POP_REAR, 32'hFFFF_FFFF);
    wait_until_idle();

    // A capacity of zero acts as one slot: full after a single word.
    write_capacity(5'd0);
    add_op(dq_pkg::OP_PUSH_REAR, 32'h0000_0001);
    add_op(dq_pkg::OP_PUSH_FRONT, 32'h0000_0002);
    add_op(dq_pkg::OP_POP_FRONT, 32'h0);
    add_op(dq_pkg::OP_POP_REAR, 32'h0);
    add_op(dq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
    add_op(dq_pkg::OP_PUSH_REAR, 32'h0000_0003);
    add_op(dq_pkg::OP_POP_REAR, 32'h0);
    wait_until_idle();

    caps.push_back(5'($urandom_range(1, 16)));
    caps.push_back(5'($urandom_range(1, 16)));
    caps.push_back(5'd16);

    // Each setting runs fill-leaning, drain-leaning and balanced stretches,
    // so full and empty are hit many times at every capacity. The queue is
    // usually left holding words when the next capacity is written.
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      for (int n = 0; n < OPS_PER_RUN; n++) begin
        if (bias_left == 0) begin
          case ($urandom_range(0, 2))
            0:       push_pct = 75;
            1:       push_pct = 25;
            default: push_pct = 50;
          endcase
          bias_left = $urandom_range(10, 40);
        end
        bias_left--;
        pending_ops.push_back(random_op(push_pct));
      end
      wait_until_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
